@@ hdl/asn1_time_to_epoch_seconds_assert.svh @@
// assertion macros shared by the time string converter
`ifndef ASN1_TIME_TO_EPOCH_SECONDS_ASSERT_SVH
`define ASN1_TIME_TO_EPOCH_SECONDS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define A1TE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("a1te assertion failed");

// antecedent implies consequent in the next cycle
`define A1TE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("a1te assertion failed");

`endif

@@ hdl/a1te_pkg.sv @@
// types, constants and helper functions of the time string converter
`timescale 1ns / 1ps

package a1te_pkg;

  localparam int EPOCH_W    = 39;
  localparam int TW         = 40;
  localparam int DIG_SPAN   = 17;

  localparam int CALC_STAGES = 9;
  localparam int CALC_CNT_W  = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam int POS_SEP_A  = 10;
  localparam int POS_SEP_B  = 12;
  localparam int POS_ZONE_A = 14;
  localparam int POS_ZONE_B = 16;

  localparam logic [6:0] PIVOT_RESET = 7'd50;

  localparam int CENTURY       = 100;
  localparam int YEAR_1900     = 1900;
  localparam int YEAR_2000     = 2000;
  localparam int ERA_YEARS     = 400;
  localparam int ERA_DAYS      = 146097;
  localparam int YEAR_DAYS     = 365;
  localparam int MONTHS        = 12;
  localparam int MON_RECIP     = 171;
  localparam int MON_SHIFT     = 11;
  localparam int ERA_RECIP     = 10486;
  localparam int ERA_SHIFT     = 22;
  localparam int DAYS_BIAS_P1  = 865566;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int MAX_ZONE_HOUR = 23;
  localparam int MAX_ZONE_MIN  = 59;

  typedef struct packed {
    logic       format;
    logic [7:0] char_byte;
    logic       last_char;
  } a1te_in_t;

  typedef struct packed {
    logic signed [EPOCH_W-1:0] epoch_seconds;
    logic                      error;
  } a1te_out_t;

  typedef struct packed {
    logic capture;
    logic last;
    logic load_out;
  } a1te_cmd_t;

  typedef struct packed {
    logic last_char;
  } a1te_sts_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    return is_digit(c) ? c[3:0] : 4'd0;
  endfunction

  function automatic logic [6:0] two_digit(input logic [3:0] hi, input logic [3:0] lo);
    return 7'(hi) * 7'd10 + 7'(lo);
  endfunction

  // day of year of the first of a month, year starting in march
  function automatic logic [8:0] doy_of_month(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] centuries_of(input logic [8:0] yoe);
    logic [1:0] c;
    if (yoe >= 9'd300) begin
      c = 2'd3;
    end else if (yoe >= 9'd200) begin
      c = 2'd2;
    end else if (yoe >= 9'd100) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

endpackage

@@ hdl/a1te_ctrl.sv @@
// controller: request acceptance, calculation sequencing and result hand-off
`timescale 1ns / 1ps
`include "asn1_time_to_epoch_seconds_assert.svh"

module a1te_ctrl import a1te_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  a1te_sts_t sts_i,
  output a1te_cmd_t cmd_o
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CALC
  } state_e;

  state_e                  state_q;
  logic [CALC_CNT_W-1:0]   cnt_q;
  logic                    in_ready_q;
  logic                    out_valid_q;
  logic                    calc_done;
  logic                    slot_free;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  assign calc_done = (state_q == ST_CALC) && (cnt_q == CALC_CNT_W'(CALC_STAGES));
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.capture  = in_valid_i && in_ready_q;
    cmd_o.last     = in_valid_i && in_ready_q && sts_i.last_char;
    cmd_o.load_out = calc_done && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.last) begin
            state_q    <= ST_CALC;
            cnt_q      <= '0;
            in_ready_q <= 1'b0;
          end
        end
        ST_CALC: begin
          if (!calc_done) begin
            cnt_q <= cnt_q + CALC_CNT_W'(1);
          end else if (slot_free) begin
            in_ready_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `A1TE_ASSERT_NEXT(a_last_starts_calc, clk_i, rst_ni, cmd_o.last, (state_q == ST_CALC) && (cnt_q == '0))
  `A1TE_ASSERT_NEXT(a_load_gives_valid, clk_i, rst_ni, cmd_o.load_out, out_valid_o && in_ready_o)
  `A1TE_ASSERT_NEXT(a_cnt_advances, clk_i, rst_ni, (state_q == ST_CALC) && !calc_done, cnt_q == CALC_CNT_W'($past(cnt_q) + 1'b1))

endmodule

@@ hdl/a1te_dp.sv @@
// datapath: character store, field decode and civil date to seconds pipeline
`timescale 1ns / 1ps

module a1te_dp import a1te_pkg::*; #(
  parameter int MAX_CHARS = 17
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  a1te_cmd_t  cmd_i,
  output a1te_sts_t  sts_o,
  input  a1te_in_t   in_req_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  output a1te_out_t  out_req_o
);

  localparam int CNT_W = $clog2(MAX_CHARS + 2);

  logic [CNT_W-1:0] char_count_q;
  logic             bad_q;
  logic [7:0]       sep0_q;
  logic [7:0]       sep1_q;
  logic [6:0]       year_pivot_q;

  logic [3:0]       dstore_q [MAX_CHARS];
  logic [3:0]       dig_w    [DIG_SPAN];

  logic             fmt_q;
  logic [7:0]       c_q;
  logic [CNT_W-1:0] pos_q;
  logic             bad_cap_q;

  logic             in_dig;

  assign sts_o.last_char = in_req_i.last_char;
  assign in_dig          = is_digit(in_req_i.char_byte);

  // string tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= '0;
      bad_q        <= 1'b0;
      sep0_q       <= '0;
      sep1_q       <= '0;
      year_pivot_q <= PIVOT_RESET;
    end else begin
      if (cfg_we_i) begin
        year_pivot_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        if (char_count_q == '0) begin
          sep0_q <= '0;
          sep1_q <= '0;
        end
        if (char_count_q == CNT_W'(POS_SEP_A)) begin
          sep0_q <= in_req_i.char_byte;
        end
        if (char_count_q == CNT_W'(POS_SEP_B)) begin
          sep1_q <= in_req_i.char_byte;
        end
        if (cmd_i.last) begin
          char_count_q <= '0;
          bad_q        <= 1'b0;
        end else begin
          if (!in_dig && (char_count_q != CNT_W'(POS_SEP_A)) &&
              (char_count_q != CNT_W'(POS_SEP_B))) begin
            bad_q <= 1'b1;
          end
          if (char_count_q <= CNT_W'(MAX_CHARS)) begin
            char_count_q <= char_count_q + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < MAX_CHARS; i++) begin
        if (char_count_q == CNT_W'(i)) begin
          dstore_q[i] <= digit_val(in_req_i.char_byte);
        end
      end
    end
    if (cmd_i.last) begin
      fmt_q     <= in_req_i.format;
      c_q       <= in_req_i.char_byte;
      pos_q     <= char_count_q;
      bad_cap_q <= bad_q;
    end
  end

  for (genvar g = 0; g < DIG_SPAN; g++) begin : g_dig
    if (g < MAX_CHARS) begin : g_real
      assign dig_w[g] = dstore_q[g];
    end else begin : g_zero
      assign dig_w[g] = 4'd0;
    end
  end

  // stage 1: validate the string and decode fields
  logic              d_err;
  logic [13:0]       d_year;
  logic signed [7:0] d_mon0;
  logic [6:0]        d_mday, d_hour, d_mins, d_sec, d_oh, d_om;
  logic              d_zone, d_zminus;

  logic              s1_err;
  logic [13:0]       s1_year;
  logic signed [7:0] s1_mon0;
  logic [6:0]        s1_mday, s1_hour, s1_mins, s1_sec, s1_oh, s1_om;
  logic              s1_zone, s1_zminus;

  always_comb begin
    logic [6:0] t0, t2, t4, t6, t8, t10, t11, t12, t13, t15;
    logic       len11, len13, len15, len17, zform, j12;
    logic       dig0, dig1, cdig;
    logic [7:0] sep;
    logic       gen_err, utc_err;
    logic [6:0] mon_f;

    t0  = two_digit(dig_w[0],  dig_w[1]);
    t2  = two_digit(dig_w[2],  dig_w[3]);
    t4  = two_digit(dig_w[4],  dig_w[5]);
    t6  = two_digit(dig_w[6],  dig_w[7]);
    t8  = two_digit(dig_w[8],  dig_w[9]);
    t10 = two_digit(dig_w[10], dig_w[11]);
    t11 = two_digit(dig_w[11], dig_w[12]);
    t12 = two_digit(dig_w[12], dig_w[13]);
    t13 = two_digit(dig_w[13], dig_w[14]);
    t15 = two_digit(dig_w[15], dig_w[16]);

    len11 = (pos_q == CNT_W'(POS_SEP_A));
    len13 = (pos_q == CNT_W'(POS_SEP_B));
    len15 = (pos_q == CNT_W'(POS_ZONE_A));
    len17 = (pos_q == CNT_W'(POS_ZONE_B));
    zform = len11 || len13;
    j12   = len13 || len17;
    dig0  = is_digit(sep0_q);
    dig1  = is_digit(sep1_q);
    cdig  = is_digit(c_q);
    sep   = zform ? c_q : (len15 ? sep0_q : sep1_q);

    gen_err = !len15 || (c_q != CHAR_Z) || !dig0 || !dig1;
    utc_err = !(len11 || len13 || len15 || len17) ||
              (zform ? (sep != CHAR_Z) : ((sep != CHAR_PLUS) && (sep != CHAR_MINUS))) ||
              (j12 && !dig0) || (len15 && !dig1) || (!zform && !cdig);

    d_err = (pos_q >= CNT_W'(MAX_CHARS)) || bad_cap_q || (fmt_q ? gen_err : utc_err);

    if (fmt_q) begin
      d_year = 14'(t0) * 14'(CENTURY) + 14'(t2);
      mon_f  = t4;
      d_mday = t6;
      d_hour = t8;
      d_mins = t10;
      d_sec  = t12;
    end else begin
      d_year = (t0 < year_pivot_q) ? 14'(YEAR_2000) + 14'(t0) : 14'(YEAR_1900) + 14'(t0);
      mon_f  = t2;
      d_mday = t4;
      d_hour = t6;
      d_mins = t8;
      d_sec  = j12 ? t10 : 7'd0;
    end
    d_mon0   = $signed(8'(mon_f) - 8'd1);
    d_oh     = j12 ? t13 : t11;
    d_om     = j12 ? t15 : t13;
    d_zone   = !fmt_q && !zform;
    d_zminus = (sep == CHAR_MINUS);
  end

  // stage 2: month carry, march-based year and month, time of day and zone offset
  logic [13:0] s2_yp;
  logic [3:0]  s2_mp;
  logic [18:0] s2_hms, s2_off;
  logic        s2_zone, s2_zminus, s2_zbad;

  logic [14:0] n_qprod;
  logic [3:0]  n_q;
  logic [6:0]  n_rem;
  logic [3:0]  n_rm;
  logic [15:0] n_year;

  always_comb begin
    n_qprod = 15'(s1_mon0[6:0]) * 15'(MON_RECIP);
    n_q     = n_qprod[MON_SHIFT +: 4];
    n_rem   = s1_mon0[6:0] - 7'(n_q) * 7'(MONTHS);
    n_rm    = s1_mon0[7] ? 4'd11 : n_rem[3:0];
    n_year  = 16'(s1_year) + 16'(ERA_YEARS)
            + (s1_mon0[7] ? 16'd0 : 16'(n_q))
            - 16'(s1_mon0[7]) - 16'(n_rm < 4'd2);
  end

  // stage 3 to 9 registers
  logic [4:0]              s3_era;
  logic [8:0]              s4_yoe, s4_doy;
  logic [21:0]             s5_era_days;
  logic [17:0]             s5_doe;
  logic signed [23:0]      s6_days;
  logic signed [TW-1:0]    s7_prod;
  logic signed [TW-1:0]    s8_t;
  logic                    s8_err;
  logic signed [EPOCH_W-1:0] s9_epoch;
  logic                    s9_err;

  logic [27:0]             e_prod;
  logic signed [17:0]      secs_day_c;
  logic signed [TW-1:0]    p_tpre, p_tz, p_off;
  logic                    p_err9;
  logic signed [TW-1:0]    p_t9;

  assign e_prod     = 28'(s2_yp) * 28'(ERA_RECIP);
  assign secs_day_c = 18'(SECS_PER_DAY);
  assign p_tpre     = s7_prod + TW'($signed({1'b0, s2_hms}));
  assign p_off      = TW'($signed({1'b0, s2_off}));
  assign p_tz       = s2_zminus ? (s8_t + p_off) : (s8_t - p_off);

  always_comb begin
    if (s2_zone) begin
      p_err9 = s8_err || s2_zbad || (p_tz == {TW{1'b1}});
      p_t9   = p_tz;
    end else begin
      p_err9 = s8_err;
      p_t9   = s8_t;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_err    <= d_err;
    s1_year   <= d_year;
    s1_mon0   <= d_mon0;
    s1_mday   <= d_mday;
    s1_hour   <= d_hour;
    s1_mins   <= d_mins;
    s1_sec    <= d_sec;
    s1_oh     <= d_oh;
    s1_om     <= d_om;
    s1_zone   <= d_zone;
    s1_zminus <= d_zminus;

    s2_yp     <= n_year[13:0];
    s2_mp     <= (n_rm >= 4'd2) ? n_rm - 4'd2 : n_rm + 4'd10;
    s2_hms    <= 19'(s1_hour) * 19'(SECS_PER_HOUR) + 19'(s1_mins) * 19'(SECS_PER_MIN)
               + 19'(s1_sec);
    s2_off    <= 19'(s1_oh) * 19'(SECS_PER_HOUR) + 19'(s1_om) * 19'(SECS_PER_MIN);
    s2_zone   <= s1_zone;
    s2_zminus <= s1_zminus;
    s2_zbad   <= (s1_oh > 7'(MAX_ZONE_HOUR)) || (s1_om > 7'(MAX_ZONE_MIN));

    s3_era    <= e_prod[ERA_SHIFT +: 5];

    s4_yoe    <= 9'(s2_yp - 14'(s3_era) * 14'(ERA_YEARS));
    s4_doy    <= doy_of_month(s2_mp);

    s5_doe    <= 18'(s4_yoe) * 18'(YEAR_DAYS) + 18'(s4_yoe >> 2)
               - 18'(centuries_of(s4_yoe)) + 18'(s4_doy);
    s5_era_days <= 22'(s3_era) * 22'(ERA_DAYS);

    s6_days   <= $signed(24'(s5_era_days) + 24'(s5_doe) + 24'(s1_mday)
                         - 24'(DAYS_BIAS_P1));

    s7_prod   <= TW'(s6_days) * TW'(secs_day_c);

    s8_t      <= p_tpre;
    s8_err    <= s1_err || (p_tpre == {TW{1'b1}});

    s9_err    <= p_err9;
    s9_epoch  <= p_err9 ? '0 : p_t9[EPOCH_W-1:0];

    if (cmd_i.load_out) begin
      out_req_o.epoch_seconds <= s9_epoch;
      out_req_o.error         <= s9_err;
    end
  end

endmodule

@@ hdl/asn1_time_to_epoch_seconds.sv @@
// top level: ASN.1 UTCTime / GeneralizedTime string to signed epoch seconds
`timescale 1ns / 1ps

// Characters of one time string arrive one request per cycle while in_ready_o
// is high, the final one marked by last_char. Inner characters give no result.
// The marked character freezes the string and starts a nine stage calendar
// pipeline (era, year of era, day count, seconds, zone offset); the result is
// held in an output register until taken. in_ready_o stays low from the last
// character until that result enters the output register, which waits if the
// previous result has not been taken yet.
// year_pivot may be written at any idle time and is 50 after reset.
module asn1_time_to_epoch_seconds import a1te_pkg::*; #(
  parameter int MAX_CHARS = 17
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  a1te_in_t   in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output a1te_out_t  out_req_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);

  a1te_cmd_t cmd;
  a1te_sts_t sts;

  a1te_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  a1te_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_req_o   (out_req_o)
  );

endmodule
